// ----- rtl/petri_net_firing_engine_defines.svh -----
// ---------------------------------------------------------------------------
// Petri net firing engine assertion macros
// Shared concurrent check forms, clocked on the rising edge, off in reset.
// ---------------------------------------------------------------------------
`ifndef PETRI_NET_FIRING_ENGINE_DEFINES_SVH
`define PETRI_NET_FIRING_ENGINE_DEFINES_SVH

// same-cycle implication
`define PNFE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PNFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pnfe_pkg.sv -----
// ---------------------------------------------------------------------------
// Petri net firing engine package
// Sizes, operation codes, shared types and the marking function.
// ---------------------------------------------------------------------------
package pnfe_pkg;

    localparam int PLACES      = 32;
    localparam int TRANSITIONS = 32;
    localparam int TOKEN_BITS  = 4;

    localparam int COL_W      = 32;
    localparam int IDX_W      = 5;
    localparam int TV_W       = 4;
    localparam int VIS_PLACES = (PLACES < COL_W) ? PLACES : COL_W;
    localparam int VIS_TRANS  = (TRANSITIONS < COL_W) ? TRANSITIONS : COL_W;
    localparam int TRANS_AW   = (VIS_TRANS > 1) ? $clog2(VIS_TRANS) : 1;
    localparam int PLACE_AW   = (VIS_PLACES > 1) ? $clog2(VIS_PLACES) : 1;
    localparam int TOKEN_MAX_INT = (1 << TOKEN_BITS) - 1;

    localparam logic [TOKEN_BITS-1:0] TOKEN_MAX = '1;
    localparam logic [COL_W-1:0] PLACE_MASK =
        (PLACES >= COL_W) ? {COL_W{1'b1}} : COL_W'((64'd1 << VIS_PLACES) - 64'd1);

    typedef enum logic [1:0] {
        OP_LOAD_IN    = 2'd0,
        OP_LOAD_OUT   = 2'd1,
        OP_SET_TOKENS = 2'd2,
        OP_FIRE       = 2'd3
    } t_op;

    typedef logic [VIS_TRANS-1:0][COL_W-1:0]       t_col_arr;
    typedef logic [VIS_PLACES-1:0][TOKEN_BITS-1:0] t_cnt_arr;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] trans;
        logic             sat;
    } t_fire_res;

    function automatic logic [COL_W-1:0] pnfe_marked(input t_cnt_arr cnt);
        logic [COL_W-1:0] m;
        m = '0;
        for (int p = 0; p < VIS_PLACES; p++) begin
            m[p] = |cnt[p];
        end
        return m;
    endfunction

endpackage

// ----- rtl/pnfe_fire_unit.sv -----
// ---------------------------------------------------------------------------
// Petri net fire unit
// Tests all transitions at once, picks the lowest enabled one and forms the
// token counts after it fires.
// ---------------------------------------------------------------------------
module pnfe_fire_unit
    import pnfe_pkg::*;
(
    input  t_col_arr  i_in_cols,
    input  t_col_arr  i_out_cols,
    input  t_cnt_arr  i_cnt,
    output t_cnt_arr  o_cnt,
    output t_fire_res o_res
);

    logic [COL_W-1:0]     w_marked;
    logic [VIS_TRANS-1:0] w_enabled;
    logic [TRANS_AW-1:0]  w_sel;
    logic [COL_W-1:0]     w_ic;
    logic [COL_W-1:0]     w_oc;
    logic                 w_hit;
    logic [IDX_W-1:0]     w_trans;
    logic                 w_sat;

    always_comb begin
        w_marked = pnfe_marked(i_cnt);
        for (int t = 0; t < VIS_TRANS; t++) begin
            w_enabled[t] = (|i_in_cols[t]) && ((i_in_cols[t] & ~w_marked) == '0);
        end
    end

    always_comb begin
        w_hit   = 1'b0;
        w_trans = '0;
        w_sel   = '0;
        for (int t = VIS_TRANS - 1; t >= 0; t--) begin
            if (w_enabled[t]) begin
                w_hit   = 1'b1;
                w_trans = IDX_W'(t);
                w_sel   = TRANS_AW'(t);
            end
        end
    end

    assign w_ic = w_hit ? i_in_cols[w_sel]  : '0;
    assign w_oc = w_hit ? i_out_cols[w_sel] : '0;

    // take before add: a place in both columns keeps its count
    always_comb begin
        w_sat = 1'b0;
        o_cnt = i_cnt;
        for (int p = 0; p < VIS_PLACES; p++) begin
            if (w_oc[p] && !w_ic[p]) begin
                if (i_cnt[p] == TOKEN_MAX) begin
                    w_sat = 1'b1;
                end else begin
                    o_cnt[p] = i_cnt[p] + TOKEN_BITS'(1);
                end
            end else if (w_ic[p] && !w_oc[p]) begin
                o_cnt[p] = i_cnt[p] - TOKEN_BITS'(1);
            end
        end
    end

    assign o_res = '{hit: w_hit, trans: w_trans, sat: w_sat};

endmodule

// ----- rtl/petri_net_firing_engine.sv -----
// ---------------------------------------------------------------------------
// Petri net firing engine
// Holds a net of input/output columns and token counts; loads and fires it.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_op, i_index, i_column_bits, i_token_value with
//   start high; the word is taken at the rising edge where busy is low. busy
//   never rises, so one word can be taken every clock cycle.
//   Result channel: o_strobe is high for one cycle with o_fired,
//   o_fired_transition, o_marked_places and o_saturated. The receiver must
//   take it in that cycle; it cannot stall the block.
//   Registers: a word taken at an edge passes through the input register,
//   then the result register, whose outputs drive the result ports. One
//   word can be taken per cycle; the enable test, lowest-index pick and token
//   update of a fire step all sit between those two registers.
//   Reset (i_rst_n low at an edge) clears all columns and token counts and
//   drops any word in flight. No clearing pass is needed afterwards.
// ---------------------------------------------------------------------------
module petri_net_firing_engine
    import pnfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_op,
    input  logic [IDX_W-1:0] i_index,
    input  logic [COL_W-1:0] i_column_bits,
    input  logic [TV_W-1:0]  i_token_value,
    output logic             o_strobe,
    output logic             o_fired,
    output logic [IDX_W-1:0] o_fired_transition,
    output logic [COL_W-1:0] o_marked_places,
    output logic             o_saturated
);

`include "petri_net_firing_engine_defines.svh"

    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [IDX_W-1:0] r_s1_index;
    logic [COL_W-1:0] r_s1_column_bits;
    logic [TV_W-1:0]  r_s1_token_value;

    t_col_arr r_in_cols,  n_in_cols;
    t_col_arr r_out_cols, n_out_cols;
    t_cnt_arr r_cnt,      n_cnt;
    t_cnt_arr w_fire_cnt;
    t_fire_res w_fire;

    logic             r_strobe;
    logic             r_fired, n_fired;
    logic [IDX_W-1:0] r_fired_transition, n_fired_transition;
    logic [COL_W-1:0] r_marked_places;
    logic             r_saturated, n_saturated;

    logic [TOKEN_BITS-1:0] w_tv_clamped;
    logic                  w_trans_ok;
    logic                  w_place_ok;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_s1_op          <= t_op'(i_op);
            r_s1_index       <= i_index;
            r_s1_column_bits <= i_column_bits;
            r_s1_token_value <= i_token_value;
        end
    end

    pnfe_fire_unit u_fire (
        .i_in_cols  (r_in_cols),
        .i_out_cols (r_out_cols),
        .i_cnt      (r_cnt),
        .o_cnt      (w_fire_cnt),
        .o_res      (w_fire)
    );

    assign w_trans_ok   = int'(r_s1_index) < VIS_TRANS;
    assign w_place_ok   = int'(r_s1_index) < VIS_PLACES;
    assign w_tv_clamped = (int'(r_s1_token_value) > TOKEN_MAX_INT) ?
                          TOKEN_MAX : TOKEN_BITS'(r_s1_token_value);

    always_comb begin
        n_in_cols          = r_in_cols;
        n_out_cols         = r_out_cols;
        n_cnt              = r_cnt;
        n_fired            = 1'b0;
        n_fired_transition = '0;
        n_saturated        = 1'b0;
        if (r_s1_valid) begin
            case (r_s1_op)
                OP_LOAD_IN: begin
                    if (w_trans_ok) begin
                        n_in_cols[r_s1_index[TRANS_AW-1:0]] = r_s1_column_bits & PLACE_MASK;
                    end
                end
                OP_LOAD_OUT: begin
                    if (w_trans_ok) begin
                        n_out_cols[r_s1_index[TRANS_AW-1:0]] = r_s1_column_bits & PLACE_MASK;
                    end
                end
                OP_SET_TOKENS: begin
                    if (w_place_ok) begin
                        n_cnt[r_s1_index[PLACE_AW-1:0]] = w_tv_clamped;
                    end
                end
                OP_FIRE: begin
                    n_cnt              = w_fire_cnt;
                    n_fired            = w_fire.hit;
                    n_fired_transition = w_fire.trans;
                    n_saturated        = w_fire.sat;
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cols  <= '0;
            r_out_cols <= '0;
            r_cnt      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_in_cols  <= n_in_cols;
            r_out_cols <= n_out_cols;
            r_cnt      <= n_cnt;
            r_strobe   <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_fired            <= n_fired;
            r_fired_transition <= n_fired_transition;
            r_marked_places    <= pnfe_marked(n_cnt);
            r_saturated        <= n_saturated;
        end
    end

    assign o_strobe           = r_strobe;
    assign o_fired            = r_fired;
    assign o_fired_transition = r_fired_transition;
    assign o_marked_places    = r_marked_places;
    assign o_saturated        = r_saturated;

    `PNFE_ASSERT_NEXT(a_word_gives_result, i_clk, i_rst_n, r_s1_valid, o_strobe,
        "taken word produced no result")
    `PNFE_ASSERT_NOW(a_marked_matches, i_clk, i_rst_n, o_strobe,
        o_marked_places == pnfe_marked(r_cnt), "marked places differ from counts")
    `PNFE_ASSERT_NEXT(a_load_no_fire, i_clk, i_rst_n, r_s1_valid && (r_s1_op != OP_FIRE),
        !o_fired && !o_saturated, "load or set word reported a firing")
    `PNFE_ASSERT_NOW(a_sat_needs_fire, i_clk, i_rst_n, o_strobe && o_saturated,
        o_fired, "saturation without a fired transition")

endmodule
